// ===== design/qdc_pkg.sv =====
// ---------------------------------------------------------------------------
// QDC decoder package
// Word type codes, flow codes, register indexes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package qdc_pkg;

   // word type field, bits 26:24
   localparam logic [2:0] WT_DATA   = 3'd0;
   localparam logic [2:0] WT_HEADER = 3'd2;
   localparam logic [2:0] WT_EOB    = 3'd4;

   localparam int CHARGE_BITS = 12;
   localparam logic signed [15:0] OVERFLOW_CHARGE  = 16'sd5000;
   localparam logic signed [15:0] UNDERFLOW_CHARGE = -16'sd1;

   // register indexes, byte address 4*index
   localparam logic [1:0] CSR_BOARD_VARIANT = 2'd0;
   localparam logic [1:0] CSR_NOT_FOUND     = 2'd1;
   localparam logic [1:0] CSR_MIN_CHANNELS  = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic write;
   } store_ctl_type;

endpackage

`default_nettype wire

// ===== design/qdc_req_if.sv =====
// ---------------------------------------------------------------------------
// QDC request channel
// Valid/ready channel carrying one readout word per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface qdc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

`default_nettype wire

// ===== design/qdc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// QDC response channel
// Valid/ready channel carrying one decoded charge slot per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface qdc_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic               range_sel;
   logic [3:0]         channel;
   logic signed [15:0] charge;
   logic [31:0]        event_number;
   logic               last;

   modport source (output valid, output status, output range_sel, output channel,
                   output charge, output event_number, output last, input ready);
   modport sink   (input valid, input status, input range_sel, input channel,
                   input charge, input event_number, input last, output ready);
endinterface

`default_nettype wire

// ===== design/qdc_slot_store.sv =====
// ---------------------------------------------------------------------------
// QDC charge slot store
// Flop array of charge slots: one write port, block clear, one read port.
// ---------------------------------------------------------------------------
`default_nettype none

module qdc_slot_store import qdc_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire store_ctl_type      ctl,
   input  wire logic signed [15:0] clear_value,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic signed [15:0] wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic signed [15:0]      rd_data
);

   logic signed [15:0] slot_ff [DEPTH];
   logic signed [15:0] slot_in [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (ctl.clear) begin
            slot_in[i] = clear_value;
         end else if (ctl.write && (wr_addr == AW'(i))) begin
            slot_in[i] = wr_data;
         end else begin
            slot_in[i] = slot_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (reset) begin
            slot_ff[i] <= '0;
         end else begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   assign rd_data = slot_ff[rd_addr];

endmodule

`default_nettype wire

// ===== design/qdc_event_word_decoder.sv =====
// ---------------------------------------------------------------------------
// QDC event word decoder
// Decodes readout words into charge slots and emits them per event.
// ---------------------------------------------------------------------------
// Header and data words are taken while idle; a short header's status result
// is presented the cycle after the word is taken.
// An end-of-block word after a header holds the input off while the slot
// counter walks the store and sends one slot per cycle when rsp is ready.
// A pending result blocks a new word until the output register frees up.
// Reset (synchronous) clears slots to zero, event count, header flag and CSRs.
`default_nettype none

module qdc_event_word_decoder import qdc_pkg::*; #(
   parameter int CHANNELS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   qdc_req_if.sink    req_chan,
   qdc_rsp_if.source  rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SLOTS = 2 * CHANNELS;
   localparam int SW    = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [SW-1:0] CH_OFFSET = SW'(CHANNELS);

   // configuration registers
   logic               variant_ff, variant_in;
   logic signed [15:0] not_found_ff, not_found_in;
   logic [5:0]         min_ch_ff, min_ch_in;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      variant_in   = variant_ff;
      not_found_in = not_found_ff;
      min_ch_in    = min_ch_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_BOARD_VARIANT: variant_in   = csr_pwdata[0];
            CSR_NOT_FOUND:     not_found_in = csr_pwdata[15:0];
            CSR_MIN_CHANNELS:  min_ch_in    = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_BOARD_VARIANT: csr_prdata = {31'd0, variant_ff};
         CSR_NOT_FOUND:     csr_prdata = {16'd0, not_found_ff};
         CSR_MIN_CHANNELS:  csr_prdata = {26'd0, min_ch_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // word decode
   logic [31:0]        word;
   logic [2:0]         kind;
   logic               accept;
   logic               range_bit;
   logic [3:0]         chan;
   logic               chan_ok;
   logic signed [15:0] charge_val;
   logic               hdr_short;
   logic [SW-1:0]      wr_slot;

   assign word   = req_chan.data_word;
   assign kind   = word[26:24];
   assign accept = req_chan.valid && req_chan.ready;

   assign range_bit = variant_ff ? word[17] : word[16];
   assign chan      = variant_ff ? {1'b0, word[20:18]} : word[20:17];
   assign chan_ok   = {1'b0, chan} < 5'(CHANNELS);
   assign wr_slot   = range_bit ? CH_OFFSET + SW'(chan) : SW'(chan);
   assign hdr_short = word[13:8] < min_ch_ff;

   always_comb begin
      // overflow wins over underflow
      if (word[12]) begin
         charge_val = OVERFLOW_CHARGE;
      end else if (word[13]) begin
         charge_val = UNDERFLOW_CHARGE;
      end else begin
         charge_val = {{(16 - CHARGE_BITS){1'b0}}, word[CHARGE_BITS-1:0]};
      end
   end

   store_ctl_type store_ctl;
   logic          eob_go;

   assign store_ctl.clear = accept && (kind == WT_HEADER);
   assign store_ctl.write = accept && (kind == WT_DATA) && chan_ok;

   // event state
   logic        header_seen_ff, header_seen_in;
   logic [31:0] event_count_ff, event_count_in;

   assign header_seen_in = header_seen_ff || store_ctl.clear;
   assign eob_go         = accept && (kind == WT_EOB) && header_seen_ff;
   assign event_count_in = eob_go ? event_count_ff + 32'd1 : event_count_ff;

   // sequencer
   state_type     state_ff, state_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          out_adv;
   logic          emit_load;
   logic          hdr_load;
   logic          req_ready_c;

   assign out_adv = !rsp_chan.valid || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (eob_go) state_in = ST_EMIT;
         ST_EMIT: if (out_adv && (cnt_ff == LAST_SLOT)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready_c = 1'b0;
      emit_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready_c = out_adv;
         ST_EMIT: emit_load   = out_adv;
         default: ;
      endcase
   end

   assign req_chan.ready = req_ready_c;
   assign hdr_load       = store_ctl.clear && hdr_short;

   always_comb begin
      cnt_in = cnt_ff;
      if (eob_go) begin
         cnt_in = '0;
      end else if (emit_load) begin
         cnt_in = cnt_ff + SW'(1);
      end
   end

   // slot store
   logic signed [15:0] rd_charge;
   logic               rd_hi;
   logic [SW-1:0]      rd_chan;

   qdc_slot_store #(
      .DEPTH (SLOTS),
      .AW    (SW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (store_ctl),
      .clear_value (not_found_ff),
      .wr_addr     (wr_slot),
      .wr_data     (charge_val),
      .rd_addr     (cnt_ff),
      .rd_data     (rd_charge)
   );

   assign rd_hi   = cnt_ff >= CH_OFFSET;
   assign rd_chan = rd_hi ? cnt_ff - CH_OFFSET : cnt_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_range_ff, rsp_range_in;
   logic [3:0]         rsp_chan_ff, rsp_chan_in;
   logic signed [15:0] rsp_charge_ff, rsp_charge_in;
   logic [31:0]        rsp_event_ff, rsp_event_in;
   logic               rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_range_in  = rsp_range_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_last_in   = rsp_last_ff;
      if (hdr_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b1;
         rsp_range_in  = 1'b0;
         rsp_chan_in   = '0;
         rsp_charge_in = '0;
         rsp_event_in  = '0;
         rsp_last_in   = 1'b1;
      end else if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b0;
         rsp_range_in  = rd_hi;
         rsp_chan_in   = 4'(rd_chan);
         rsp_charge_in = rd_charge;
         rsp_event_in  = event_count_ff;
         rsp_last_in   = cnt_ff == LAST_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff     <= 1'b0;
         not_found_ff   <= '0;
         min_ch_ff      <= '0;
         header_seen_ff <= 1'b0;
         event_count_ff <= '0;
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         variant_ff     <= variant_in;
         not_found_ff   <= not_found_in;
         min_ch_ff      <= min_ch_in;
         header_seen_ff <= header_seen_in;
         event_count_ff <= event_count_in;
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.range_sel    = rsp_range_ff;
   assign rsp_chan.channel      = rsp_chan_ff;
   assign rsp_chan.charge       = rsp_charge_ff;
   assign rsp_chan.event_number = rsp_event_ff;
   assign rsp_chan.last         = rsp_last_ff;

`ifndef SYNTH
   // hold the input off for the whole emission run
   a_no_accept_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !req_chan.ready)
      else $error("word accepted during slot emission");

   // leave the run once the final slot is loaded
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_adv && cnt_ff == LAST_SLOT) |=> (state_ff == ST_IDLE))
      else $error("emission did not end after final slot");

   // slot results carry the current event count
   a_event_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_status_ff) |-> (rsp_event_ff == event_count_ff))
      else $error("slot result carries stale event number");

   // a status result is always a one-transaction run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> rsp_last_ff)
      else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// QDC event word decoder testbench
// Streams readout words through the decoder and checks every emitted charge
// slot against a behavioral predictor. A directed table covers the word
// types, flow codes and short headers. Randomized events follow under
// several register settings. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qdc_pkg::*;

   localparam int NUM_CH        = 16;
   localparam int NUM_SLOTS     = 2 * NUM_CH;
   localparam int IDLE_LIMIT    = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_WORDS   = 18;

   typedef struct packed {
      logic               status;
      logic               range_sel;
      logic [3:0]         channel;
      logic signed [15:0] charge;
      logic [31:0]        event_number;
      logic               last;
   } slot_rsp_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_SHORT} row_check_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [1:0]    reg_idx;
      logic [31:0]   value;
      row_check_type check;
   } stim_row_type;

   localparam slot_rsp_type SHORT_HEADER_RSP = '{status: 1'b1, range_sel: 1'b0,
      channel: 4'd0, charge: 16'sd0, event_number: 32'd0, last: 1'b1};

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   qdc_req_if req_bus();
   qdc_rsp_if rsp_bus();

   qdc_event_word_decoder #(.CHANNELS(NUM_CH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic               pv_variant;
   logic signed [15:0] pv_not_found;
   logic [5:0]         pv_min_channels;
   logic signed [15:0] charge_slots [NUM_SLOTS];
   logic [31:0]        events_done;
   logic               header_flag;
   slot_rsp_type       decoded[$];
   slot_rsp_type       awaited_slots[$];

   stim_row_type directed_rows [25];

   int burst_left;
   int words_sent;
   int results_seen;
   int events_seen;
   int settings_used;
   int mismatches;
   int idle_cycles;
   int stall_left;
   int stall_mode;
   int mode_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void decode_word(input logic [31:0] w);
      logic [2:0]         wtype;
      logic               rng;
      logic [3:0]         chan;
      logic signed [15:0] q;
      slot_rsp_type       s;
      wtype = w[26:24];
      decoded.delete();
      if (wtype == WT_HEADER) begin
         if (w[13:8] < pv_min_channels) decoded.push_back(SHORT_HEADER_RSP);
         foreach (charge_slots[i]) charge_slots[i] = pv_not_found;
         header_flag = 1'b1;
      end else if (wtype == WT_DATA) begin
         if (pv_variant == 1'b0) begin
            rng  = w[16];
            chan = w[20:17];
         end else begin
            rng  = w[17];
            chan = {1'b0, w[20:18]};
         end
         // overflow wins over underflow
         if (w[12]) q = OVERFLOW_CHARGE;
         else if (w[13]) q = UNDERFLOW_CHARGE;
         else q = $signed({4'd0, w[CHARGE_BITS-1:0]});
         if (chan < NUM_CH) charge_slots[rng * 16 + chan] = q;
      end else if (wtype == WT_EOB && header_flag) begin
         events_done = events_done + 32'd1;
         for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < NUM_CH; c++) begin
               s.status       = 1'b0;
               s.range_sel    = r[0];
               s.channel      = c[3:0];
               s.charge       = charge_slots[r * 16 + c];
               s.event_number = events_done;
               s.last         = (r == 1 && c == NUM_CH - 1);
               decoded.push_back(s);
            end
         end
      end
   endfunction

   function automatic logic [31:0] typed_word(input logic [2:0] wtype);
      logic [31:0] w;
      w = $urandom;
      w[26:24] = wtype;
      return w;
   endfunction

   // keep most charges in range, flow flags left random on about one word in eight
   function automatic logic [31:0] charge_word();
      logic [31:0] w;
      w = typed_word(WT_DATA);
      if ($urandom_range(0, 7) != 0) w[13:12] = 2'b00;
      return w;
   endfunction

   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic send_word(input logic [31:0] w, input row_check_type check);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      end
      // the word is committed once presented, so predict now: the slots of an
      // end of block may go out before this task sees the word taken
      decode_word(w);
      case (check)
         CHK_NONE: ;
         CHK_SHORT: awaited_slots.push_back(SHORT_HEADER_RSP);
         default: foreach (decoded[i]) awaited_slots.push_back(decoded[i]);
      endcase
      req_bus.valid     <= 1'b1;
      req_bus.data_word <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] mask;
      case (idx)
         CSR_BOARD_VARIANT: begin
            mask = 32'h1;
            pv_variant = val[0];
         end
         CSR_NOT_FOUND: begin
            mask = 32'hFFFF;
            pv_not_found = val[15:0];
         end
         CSR_MIN_CHANNELS: begin
            mask = 32'h3F;
            pv_min_channels = val[5:0];
         end
         default: mask = 32'h0;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      // back-to-back read of the same register
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      compare_field("csr readback", val & mask, csr_prdata & mask);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
   endtask

   // drop valid, wait out every expected slot, then let the block go idle
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (awaited_slots.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result stall pattern: modes of no stall, short stalls and long stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         case (stall_mode)
            1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
            2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 8);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      slot_rsp_type want;
      slot_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.status, rsp_bus.range_sel, rsp_bus.channel, rsp_bus.charge,
                 rsp_bus.event_number, rsp_bus.last};
         results_seen++;
         if (awaited_slots.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none, actual %p", $time, got);
         end else begin
            want = awaited_slots.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("range_sel", want.range_sel, got.range_sel);
            compare_field("channel", want.channel, got.channel);
            compare_field("charge", want.charge, got.charge);
            compare_field("event_number", want.event_number, got.event_number);
            compare_field("last", want.last, got.last);
            if (want.last && !want.status) events_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          pick;
      int          n;
      int          phase_words;
      logic [2:0]  broken_type;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_word = 32'd0;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = 4'd0;
      csr_pwdata        = 32'd0;
      pv_variant        = 1'b0;
      pv_not_found      = 16'sd0;
      pv_min_channels   = 6'd0;
      events_done       = 32'd0;
      header_flag       = 1'b0;
      foreach (charge_slots[i]) charge_slots[i] = 16'sd0;
      burst_left    = 0;
      words_sent    = 0;
      results_seen  = 0;
      events_seen   = 0;
      settings_used = 0;
      mismatches    = 0;
      idle_cycles   = 0;
      stall_left    = 0;
      stall_mode    = 0;
      mode_left     = 0;

      directed_rows = '{
         // end of block before any header, every ignored word type, then a zero data word
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0400_0000, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hF9FF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFBFF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFDFF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFEFF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFFFF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0000_0000, CHK_NONE},
         // short headers at the channel-count extremes
         '{ROW_CSR,  CSR_MIN_CHANNELS,  32'd63,        CHK_MODEL},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0200_0000, CHK_SHORT},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0200_3F00, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0200_3E00, CHK_SHORT},
         '{ROW_CSR,  CSR_NOT_FOUND,     32'h0000_8000, CHK_MODEL},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFAFF_C0FF, CHK_SHORT},
         // full-scale charge, top slot, overflow winning, underflow, then end of block
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0000_0FFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h001F_0000, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0002_3000, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0004_2000, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hFCFF_FFFF, CHK_MODEL},
         // alternate bit layout
         '{ROW_CSR,  CSR_BOARD_VARIANT, 32'd1,         CHK_MODEL},
         '{ROW_CSR,  CSR_NOT_FOUND,     32'h0000_7FFF, CHK_MODEL},
         '{ROW_CSR,  CSR_MIN_CHANNELS,  32'd0,         CHK_MODEL},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0200_0000, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h001E_0800, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'hF8FF_FFFF, CHK_NONE},
         '{ROW_WORD, CSR_BOARD_VARIANT, 32'h0400_0000, CHK_MODEL}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_block();
            write_csr(directed_rows[i].reg_idx, directed_rows[i].value);
         end else begin
            send_word(directed_rows[i].value, directed_rows[i].check);
         end
      end

      for (int p = 0; p < 5; p++) begin
         drain_block();
         case (p)
            0: begin
               write_csr(CSR_BOARD_VARIANT, 32'd0);
               write_csr(CSR_NOT_FOUND, 32'h0000_8000);
               write_csr(CSR_MIN_CHANNELS, 32'd0);
            end
            1: begin
               write_csr(CSR_BOARD_VARIANT, 32'd1);
               write_csr(CSR_NOT_FOUND, 32'h0000_7FFF);
               write_csr(CSR_MIN_CHANNELS, 32'd63);
            end
            default: begin
               write_csr(CSR_BOARD_VARIANT, (p == 3) ? 32'd1 : $urandom_range(0, 1));
               write_csr(CSR_NOT_FOUND, $urandom);
               write_csr(CSR_MIN_CHANNELS, $urandom_range(0, 63));
            end
         endcase
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               // well-formed event with random content
               send_word(typed_word(WT_HEADER), CHK_MODEL);
               n = $urandom_range(0, 12);
               repeat (n) send_word(charge_word(), CHK_MODEL);
               send_word(typed_word(WT_EOB), CHK_MODEL);
               phase_words += n + 2;
            end else if (pick < 9) begin
               send_word($urandom, CHK_MODEL);
               phase_words++;
            end else begin
               // stray piece of an event
               case ($urandom_range(0, 2))
                  0: broken_type = WT_HEADER;
                  1: broken_type = WT_DATA;
                  default: broken_type = WT_EOB;
               endcase
               send_word(typed_word(broken_type), CHK_MODEL);
               phase_words++;
            end
         end
      end

      drain_block();
      repeat (8) @(negedge clock);
      $display("Sent %0d readout words under %0d register writes.", words_sent,
               settings_used);
      $display("Checked %0d slot transactions covering %0d complete events.",
               results_seen, events_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/qdc_pkg.sv
design/qdc_req_if.sv
design/qdc_rsp_if.sv
design/qdc_slot_store.sv
design/qdc_event_word_decoder.sv
tb/tb.sv
